// ===== rtl/core/cfca_pkg.sv =====
// Shared constants, types and the sRGB-to-linear ROM for the contrast floor color adjust block.
// No dependencies; the register file, controller, datapath and top level import this package.
package cfca_pkg;

    // Fixed-point format and search length
    localparam int LUMA_FRAC_BITS = 16;
    localparam int MAX_STEPS      = 255;
    localparam int LUMA_W         = LUMA_FRAC_BITS + 1;
    localparam logic [63:0] LUMA_ONE = 64'd1 << LUMA_FRAC_BITS;
    localparam int STEP_W         = $clog2(MAX_STEPS + 1);
    localparam int STEP_CNT_W     = $clog2(MAX_STEPS + 2);

    // Contrast floor register
    localparam int FLOOR_W = 13;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 13'd768;

    // Luminance weights, scaled by 10000
    localparam int WEIGHT_SCALE = 10000;
    localparam int WEIGHT_R     = 2126;
    localparam int WEIGHT_G     = 7152;
    localparam int WEIGHT_B     = 722;
    localparam int SUM_W        = LUMA_W + 14;

    // Divide by WEIGHT_SCALE: multiply by a truncated reciprocal, then one correction
    localparam int REC_SHIFT = SUM_W + 14;
    localparam int REC_W     = REC_SHIFT - 13;
    localparam logic [REC_W-1:0] REC_MUL = REC_W'((64'd1 << REC_SHIFT) / WEIGHT_SCALE);
    localparam int REM_W     = 15;

    // Pass test widths: 256*(20*hi+S) >= floor*(20*lo+S)
    localparam int PASS_W = LUMA_W + 5;
    localparam int LHS_W  = PASS_W + 8;
    localparam int RHS_W  = PASS_W + FLOOR_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // Table build constants
    localparam logic [63:0] LIN_LOW_SCALE  = 64'd100;
    localparam logic [63:0] LIN_LOW_DEN    = 64'd329460;
    localparam logic [63:0] LIN_HIGH_SCALE = 64'd1000;
    localparam logic [63:0] LIN_HIGH_OFS   = 64'd14025;
    localparam logic [63:0] LIN_HIGH_DEN   = 64'd269025;
    localparam logic [63:0] Q30_ONE        = 64'd1 << 30;

    typedef logic [LUMA_W-1:0] lin_table_t [256];

    typedef struct packed {
        logic accept;
        logic issue;
        logic flush;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic yb_valid;
        logic issue_done;
        logic decided;
    } dp_status_t;

    typedef struct packed {
        logic              back;
        logic [STEP_W-1:0] step;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } lum_tag_t;

    function automatic logic [63:0] fifth_power_q30(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    // Elaboration only: linear-light value of one 8-bit sRGB code, in 1/2^LUMA_FRAC_BITS
    function automatic logic [63:0] lin_entry(input int k);
        logic [63:0] kk;
        logic [63:0] num;
        logic [63:0] x;
        logic [63:0] w;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        kk = 64'(k);
        if (k <= 10) begin
            return (kk * LUMA_ONE * LIN_LOW_SCALE + LIN_LOW_DEN / 2) / LIN_LOW_DEN;
        end
        num = LIN_HIGH_SCALE * kk + LIN_HIGH_OFS;
        x   = ((num << 30) + LIN_HIGH_DEN / 2) / LIN_HIGH_DEN;
        w   = (x * x + (Q30_ONE >> 1)) >> 30;
        lo  = 64'd0;
        hi  = Q30_ONE;
        // fifth root of w by bisection
        for (int i = 0; i < 32; i++) begin
            if (lo < hi) begin
                mid = lo + (hi - lo + 64'd1) / 2;
                if (fifth_power_q30(mid) <= w) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return (w * lo + (64'd1 << (59 - LUMA_FRAC_BITS))) >> (60 - LUMA_FRAC_BITS);
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        for (int k = 0; k < 256; k++) begin
            tbl[k] = LUMA_W'(lin_entry(k));
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// ===== rtl/core/cfca_regs.sv =====
// APB-style configuration register file: holds the contrast floor.
// Depends on cfca_pkg.
module cfca_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [cfca_pkg::FLOOR_W-1:0] contrast_floor
);
    import cfca_pkg::*;

    localparam logic REG_IDX_FLOOR = 1'b0;

    logic [FLOOR_W-1:0] floor_reg;
    logic [FLOOR_W-1:0] floor_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        floor_next = floor_reg;
        if (wr_en && (paddr[2] == REG_IDX_FLOOR)) begin
            floor_next = pwdata[FLOOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
        end else begin
            floor_reg <= floor_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IDX_FLOOR) begin
            prdata = {{(32 - FLOOR_W){1'b0}}, floor_reg};
        end
    end

    assign contrast_floor = floor_reg;

endmodule

// ===== rtl/core/cfca_ctrl.sv =====
// Controller: sequences accept, backdrop luminance, candidate search and result hand-off.
// Depends on cfca_pkg.
module cfca_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  cfca_pkg::dp_status_t   status,
    output cfca_pkg::ctrl_cmd_t    cmd
);
    import cfca_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_WAIT_BACK = 4'b0010,
        ST_SEARCH    = 4'b0100,
        ST_DONE      = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_WAIT_BACK;
                end
            end
            ST_WAIT_BACK: begin
                if (status.yb_valid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.issue = !status.issue_done;
                if (status.decided) begin
                    // drop the speculative candidates behind the winner
                    cmd.flush  = 1'b1;
                    cmd.issue  = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/cfca_datapath.sv =====
// Datapath: compositing, candidate generator, 9-stage luminance and contrast-test pipeline,
// result and output registers. Depends on cfca_pkg.
module cfca_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfca_pkg::ctrl_cmd_t          cmd,
    output cfca_pkg::dp_status_t         status,
    input  logic [cfca_pkg::FLOOR_W-1:0] contrast_floor,
    input  logic [7:0]                   s_back_red,
    input  logic [7:0]                   s_back_green,
    input  logic [7:0]                   s_back_blue,
    input  logic [7:0]                   s_fore_red,
    input  logic [7:0]                   s_fore_green,
    input  logic [7:0]                   s_fore_blue,
    input  logic [7:0]                   s_fore_alpha,
    output logic [7:0]                   m_out_red,
    output logic [7:0]                   m_out_green,
    output logic [7:0]                   m_out_blue,
    output logic                         m_floor_met
);
    import cfca_pkg::*;

    localparam int NUM_STAGES = 9;
    localparam logic [LUMA_W-1:0] LUMA_HALF = LUMA_W'(LUMA_ONE >> 1);

    // x/255 for x < 65535, exact
    function automatic logic [7:0] div255(input logic [16:0] v);
        logic [16:0] t;
        t = v + (v >> 8) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [7:0] step_channel(input logic [7:0] c,
                                                input logic [STEP_W-1:0] s,
                                                input logic up);
        logic [8:0] sum;
        logic [8:0] s9;
        s9  = 9'(s);
        sum = {1'b0, c} + s9;
        if (up) begin
            return sum[8] ? 8'hFF : sum[7:0];
        end
        return (s9 > {1'b0, c}) ? 8'd0 : 8'(({1'b0, c} - s9));
    endfunction

    // ---------------- compositing ----------------
    logic [7:0]  back_ch [3];
    logic [7:0]  fore_ch [3];
    logic [15:0] mul_b_reg [3];
    logic [15:0] mul_f_reg [3];
    logic [7:0]  comp_reg [3];

    assign back_ch[0] = s_back_red;
    assign back_ch[1] = s_back_green;
    assign back_ch[2] = s_back_blue;
    assign fore_ch[0] = s_fore_red;
    assign fore_ch[1] = s_fore_green;
    assign fore_ch[2] = s_fore_blue;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (cmd.accept) begin
                mul_b_reg[i] <= 16'(back_ch[i]) * 16'(8'd255 - s_fore_alpha);
                mul_f_reg[i] <= 16'(fore_ch[i]) * 16'(s_fore_alpha);
            end
            comp_reg[i] <= div255(17'(mul_b_reg[i]) + 17'(mul_f_reg[i]) + 17'd127);
        end
    end

    // ---------------- candidate generator ----------------
    logic [STEP_CNT_W-1:0] step_reg;
    logic [STEP_CNT_W-1:0] step_next;
    logic [LUMA_W-1:0]     yb_reg;
    logic                  yb_valid_reg;
    logic                  yb_valid_next;
    logic                  lighten;
    logic                  issue_vld;
    lum_tag_t              tag0_next;

    assign lighten   = yb_reg < LUMA_HALF;
    assign issue_vld = cmd.accept || cmd.issue;

    always_comb begin
        step_next = step_reg;
        if (cmd.accept) begin
            step_next = '0;
        end else if (cmd.issue) begin
            step_next = step_reg + STEP_CNT_W'(1);
        end
    end

    always_comb begin
        if (cmd.accept) begin
            tag0_next.back  = 1'b1;
            tag0_next.step  = '0;
            tag0_next.red   = s_back_red;
            tag0_next.green = s_back_green;
            tag0_next.blue  = s_back_blue;
        end else begin
            // step zero is the composite itself
            tag0_next.back  = 1'b0;
            tag0_next.step  = step_reg[STEP_W-1:0];
            tag0_next.red   = step_channel(comp_reg[0], step_reg[STEP_W-1:0], lighten);
            tag0_next.green = step_channel(comp_reg[1], step_reg[STEP_W-1:0], lighten);
            tag0_next.blue  = step_channel(comp_reg[2], step_reg[STEP_W-1:0], lighten);
        end
    end

    // ---------------- luminance / test pipeline ----------------
    logic [NUM_STAGES-1:0] vld_reg;
    lum_tag_t              tag_reg [NUM_STAGES];

    logic [LUMA_W-1:0]          lr1_reg, lg1_reg, lb1_reg;
    logic [SUM_W-1:0]           pr2_reg, pg2_reg, pb2_reg;
    logic [SUM_W-1:0]           sum3_reg;
    logic [SUM_W+REC_W-1:0]     prod4_reg;
    logic [SUM_W-1:0]           sum4_reg;
    logic [LUMA_W-1:0]          q5_next;
    logic [LUMA_W-1:0]          q5_reg;
    logic [SUM_W-1:0]           qm5_reg;
    logic [SUM_W-1:0]           sum5_reg;
    logic [REM_W-1:0]           rem6;
    logic [LUMA_W-1:0]          y6_next;
    logic [LUMA_W-1:0]          y6_reg;
    logic [LUMA_W-1:0]          hi7;
    logic [LUMA_W-1:0]          lo7;
    logic [LHS_W-1:0]           lhs7_reg;
    logic [RHS_W-1:0]           rhs7_reg;
    logic                       pass8_reg;

    assign q5_next = LUMA_W'(prod4_reg >> REC_SHIFT);
    assign rem6    = REM_W'(sum5_reg - qm5_reg);
    // reciprocal quotient is short by at most one
    assign y6_next = (rem6 >= REM_W'(WEIGHT_SCALE)) ? q5_reg + LUMA_W'(1) : q5_reg;
    assign hi7     = (y6_reg > yb_reg) ? y6_reg : yb_reg;
    assign lo7     = (y6_reg > yb_reg) ? yb_reg : y6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.flush) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], issue_vld};
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg[0] <= tag0_next;
        for (int i = 1; i < NUM_STAGES; i++) begin
            tag_reg[i] <= tag_reg[i-1];
        end
        lr1_reg   <= LIN_TABLE[tag_reg[0].red];
        lg1_reg   <= LIN_TABLE[tag_reg[0].green];
        lb1_reg   <= LIN_TABLE[tag_reg[0].blue];
        pr2_reg   <= SUM_W'(lr1_reg) * SUM_W'(WEIGHT_R);
        pg2_reg   <= SUM_W'(lg1_reg) * SUM_W'(WEIGHT_G);
        pb2_reg   <= SUM_W'(lb1_reg) * SUM_W'(WEIGHT_B);
        sum3_reg  <= pr2_reg + pg2_reg + pb2_reg + SUM_W'(WEIGHT_SCALE / 2);
        prod4_reg <= (SUM_W+REC_W)'(sum3_reg) * (SUM_W+REC_W)'(REC_MUL);
        sum4_reg  <= sum3_reg;
        q5_reg    <= q5_next;
        qm5_reg   <= SUM_W'(q5_next) * SUM_W'(WEIGHT_SCALE);
        sum5_reg  <= sum4_reg;
        y6_reg    <= y6_next;
        lhs7_reg  <= {(PASS_W'(hi7) * PASS_W'(20) + PASS_W'(LUMA_ONE)), 8'd0};
        rhs7_reg  <= RHS_W'(contrast_floor) *
                     RHS_W'(PASS_W'(lo7) * PASS_W'(20) + PASS_W'(LUMA_ONE));
        pass8_reg <= CMP_W'(lhs7_reg) >= CMP_W'(rhs7_reg);
    end

    // backdrop luminance, taken as the backdrop leaves the divide stage
    always_comb begin
        yb_valid_next = yb_valid_reg;
        if (cmd.accept) begin
            yb_valid_next = 1'b0;
        end else if (vld_reg[5] && tag_reg[5].back) begin
            yb_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            yb_valid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            yb_valid_reg <= yb_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (vld_reg[5] && tag_reg[5].back) begin
            yb_reg <= y6_next;
        end
    end

    // ---------------- decision and result ----------------
    logic [7:0] res_red_reg, res_green_reg, res_blue_reg;
    logic       res_met_reg;
    logic [7:0] out_red_reg, out_green_reg, out_blue_reg;
    logic       out_met_reg;

    assign status.decided    = vld_reg[NUM_STAGES-1] && !tag_reg[NUM_STAGES-1].back &&
                               (pass8_reg ||
                                (tag_reg[NUM_STAGES-1].step == STEP_W'(MAX_STEPS)));
    assign status.yb_valid   = yb_valid_reg;
    assign status.issue_done = step_reg > STEP_CNT_W'(MAX_STEPS);

    always_ff @(posedge aclk) begin
        if (cmd.flush) begin
            res_red_reg   <= tag_reg[NUM_STAGES-1].red;
            res_green_reg <= tag_reg[NUM_STAGES-1].green;
            res_blue_reg  <= tag_reg[NUM_STAGES-1].blue;
            res_met_reg   <= pass8_reg;
        end
        if (cmd.load_out) begin
            out_red_reg   <= res_red_reg;
            out_green_reg <= res_green_reg;
            out_blue_reg  <= res_blue_reg;
            out_met_reg   <= res_met_reg;
        end
    end

    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;
    assign m_floor_met = out_met_reg;

endmodule

// ===== rtl/core/contrast_floor_color_adjust.sv =====
// The time from input transfer to result valid grows with n, the steps taken (0..255);
//   one item is in work at a time; the next is taken in once the last result is loaded.
// The 9-stage luminance and contrast-test pipeline takes one candidate per cycle while
//   searching; the search length sets the time to a result. A finished result waits in
//   the output register while the next item is taken in.
// Reset: aresetn synchronous, active low; clears control state, contrast floor returns to 3.0.
module contrast_floor_color_adjust (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_back_red,
    input  logic [7:0]  s_back_green,
    input  logic [7:0]  s_back_blue,
    input  logic [7:0]  s_fore_red,
    input  logic [7:0]  s_fore_green,
    input  logic [7:0]  s_fore_blue,
    input  logic [7:0]  s_fore_alpha,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic        m_floor_met
);
    import cfca_pkg::*;

    logic [FLOOR_W-1:0] contrast_floor;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    cfca_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .contrast_floor (contrast_floor)
    );

    cfca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cfca_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .contrast_floor (contrast_floor),
        .s_back_red     (s_back_red),
        .s_back_green   (s_back_green),
        .s_back_blue    (s_back_blue),
        .s_fore_red     (s_fore_red),
        .s_fore_green   (s_fore_green),
        .s_fore_blue    (s_fore_blue),
        .s_fore_alpha   (s_fore_alpha),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_floor_met    (m_floor_met)
    );

endmodule

// ===== rtl/core/cfca_checker.sv =====
// Port-level checker for the contrast floor color adjust top level, bound in below.
// No package dependency.
module cfca_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_red,
    input logic [7:0] m_out_green,
    input logic [7:0] m_out_blue,
    input logic       m_floor_met
);

    // items taken in but not yet delivered
    logic [1:0] open_reg;
    logic [1:0] open_next;

    always_comb begin
        open_next = open_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            open_next = open_reg + 2'd1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            open_next = open_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 2'd0;
        end else begin
            open_reg <= open_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_out_green)
                                && $stable(m_out_blue) && $stable(m_floor_met))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> open_reg != 2'd0)
        else $error("result with no item outstanding");

    a_bounded_open: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg != 2'd3)
        else $error("too many items outstanding");

endmodule

bind contrast_floor_color_adjust cfca_checker u_cfca_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_red   (m_out_red),
    .m_out_green (m_out_green),
    .m_out_blue  (m_out_blue),
    .m_floor_met (m_floor_met)
);
